### rtl/rtfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radar target frame parser package
// Frame geometry, marker bytes and the command and status types shared by
// the window, the controller, the datapath and the core.
// ----------------------------------------------------------------------------
package rtfp_pkg;

    // Frame geometry.
    localparam int TARGET_SLOTS     = 3;
    localparam int SLOT_BYTES       = 8;
    localparam int HDR_BYTES        = 4;
    localparam int TRL_BYTES        = 2;
    localparam int FRAME_LEN        = HDR_BYTES + SLOT_BYTES * TARGET_SLOTS + TRL_BYTES;
    localparam int SLOT_FIELD_BYTES = 6;

    // Derived widths.
    localparam int CNT_W      = $clog2(FRAME_LEN + 1);
    localparam int SLOT_IDX_W = (TARGET_SLOTS > 1) ? $clog2(TARGET_SLOTS) : 1;
    localparam int TCNT_W     = $clog2(TARGET_SLOTS + 1);
    localparam int SQRT_STEPS = 16;
    localparam int STEP_W     = $clog2(SQRT_STEPS);

    // Header and trailer bytes.
    localparam logic [7:0] HDR_B0 = 8'hAA;
    localparam logic [7:0] HDR_B1 = 8'hFF;
    localparam logic [7:0] HDR_B2 = 8'h03;
    localparam logic [7:0] HDR_B3 = 8'h00;
    localparam logic [7:0] TRL_B0 = 8'h55;
    localparam logic [7:0] TRL_B1 = 8'hCC;

    // Offset-binary word flip and the encoding of an empty value.
    localparam logic [15:0] SIGN_FLIP  = 16'h8000;
    localparam logic [15:0] EMPTY_WORD = 16'h8000;

    // Output transaction layout.
    localparam int OUT_FIELDS_W = 2 + 1 + 16 + 16;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Slot bytes used by the decoder: X lo/hi, Y lo/hi, speed lo/hi.
    typedef logic [SLOT_FIELD_BYTES-1:0][7:0] t_slot;
    typedef t_slot [TARGET_SLOTS-1:0]         t_slots;

    // Controller to datapath commands.
    typedef struct packed {
        logic                  dec;
        logic                  add;
        logic                  cmp;
        logic                  sqrt_init;
        logic                  sqrt_step;
        logic                  finish;
        logic [SLOT_IDX_W-1:0] slot;
    } t_dp_cmd;

    // Status seen by the controller.
    typedef struct packed {
        logic start;
        logic out_free;
    } t_ctrl_stat;

endpackage

### rtl/radar_target_frame_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radar target frame parser core
// Finds multi-target frames in a received byte stream and reports the
// number of targets and the nearest one's distance and speed.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one received serial byte per transaction and
// normally accepts a byte every cycle. A frame is a header AA FF 03 00,
// 8 bytes per target slot and a trailer 55 CC, not overlapping the last
// accepted frame. Each accepted frame yields one master transaction.
// After the byte that completes the frame the engine decodes each slot,
// forms its squared range and compares it, then runs sixteen square root
// steps. The slave channel takes a byte per cycle, but input ready drops
// only when the byte at hand could complete a frame while the previous
// frame is still in the engine or waiting behind a full output register.
// A stalled receiver holds the result in the output register; one more
// result can wait in the engine behind it.
// Reset clears the window, sets the byte counter to a full frame and clears
// the held distance to zero.
// ----------------------------------------------------------------------------
module radar_target_frame_parser_core
    import rtfp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [7:0]             i_s_axis_tdata,  // [7:0] rx_byte
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [1:0] target_count, [2] target_present, [18:3] nearest_distance_mm,
    // [34:19] nearest_speed, upper bits zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    logic                    w_accept;
    logic                    w_hit;
    logic                    w_near_frame;
    t_slots                  w_slots;
    t_dp_cmd                 w_cmd;
    t_ctrl_stat              w_stat;
    logic                    w_busy;
    logic [1:0]              w_count;
    logic                    w_present;
    logic [15:0]             w_distance;
    logic signed [15:0]      w_speed;
    logic                    r_out_valid;
    logic [OUT_TDATA_W-1:0]  r_out_data;

    // Input handshake.
    assign o_s_axis_tready = !(w_busy && w_near_frame);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    rtfp_window u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_byte       (i_s_axis_tdata),
        .o_hit        (w_hit),
        .o_near_frame (w_near_frame),
        .o_slots      (w_slots)
    );

    assign w_stat.start    = w_hit;
    assign w_stat.out_free = !r_out_valid || i_m_axis_tready;

    rtfp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (w_busy)
    );

    rtfp_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_hit),
        .i_slots    (w_slots),
        .i_cmd      (w_cmd),
        .o_count    (w_count),
        .o_present  (w_present),
        .o_distance (w_distance),
        .o_speed    (w_speed)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.finish) begin
            r_out_data <= OUT_TDATA_W'({w_speed, w_distance, w_present, w_count});
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // A frame is only detected while the engine is free.
    a_hit_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hit |-> !w_busy)
        else $error("frame detected while the engine is busy");

    // A detected frame starts the engine.
    a_hit_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hit |=> w_busy)
        else $error("engine did not start on a detected frame");

    // The present flag agrees with the target count.
    a_present_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[2] == (o_m_axis_tdata[1:0] != 2'd0)))
        else $error("target present flag disagrees with target count");

    // Without a target the speed is zero.
    a_no_target_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[2]) |-> (o_m_axis_tdata[34:19] == 16'd0))
        else $error("nonzero speed reported without a target");

endmodule

### rtl/rtfp_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame window
// Shift window over the received bytes, the byte counter since the last
// accepted frame and the header and trailer match.
// ----------------------------------------------------------------------------
module rtfp_window
    import rtfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    output logic       o_hit,
    output logic       o_near_frame,
    output t_slots     o_slots
);

    logic [FRAME_LEN-1:0][7:0] r_win;
    logic [FRAME_LEN-1:0][7:0] n_win;
    logic [CNT_W-1:0]          r_cnt;
    logic [CNT_W-1:0]          n_cnt;
    logic                      w_hdr_ok;
    logic                      w_trl_ok;

    // Window after the incoming byte; index 0 is the oldest byte.
    assign n_win = {i_byte, r_win[FRAME_LEN-1:1]};

    // Saturating byte count including the incoming byte.
    assign n_cnt = (r_cnt < CNT_W'(FRAME_LEN)) ? r_cnt + CNT_W'(1) : r_cnt;

    assign w_hdr_ok = (n_win[0] == HDR_B0) && (n_win[1] == HDR_B1) &&
                      (n_win[2] == HDR_B2) && (n_win[3] == HDR_B3);
    assign w_trl_ok = (n_win[FRAME_LEN-2] == TRL_B0) && (n_win[FRAME_LEN-1] == TRL_B1);

    // A frame is taken only once a full frame length has gone by.
    assign o_hit = i_accept && (n_cnt == CNT_W'(FRAME_LEN)) && w_hdr_ok && w_trl_ok;

    // The next byte may complete a frame.
    assign o_near_frame = (r_cnt >= CNT_W'(FRAME_LEN - 1));

    // Slot fields as they stand once the incoming byte is in.
    always_comb begin
        for (int t = 0; t < TARGET_SLOTS; t++) begin
            for (int k = 0; k < SLOT_FIELD_BYTES; k++) begin
                o_slots[t][k] = n_win[HDR_BYTES + t * SLOT_BYTES + k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
            r_cnt <= CNT_W'(FRAME_LEN);
        end else if (i_accept) begin
            r_win <= n_win;
            r_cnt <= o_hit ? '0 : n_cnt;
        end
    end

endmodule

### rtl/rtfp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Target datapath
// Slot capture, offset-binary decode, squared range, nearest search,
// bit-pair integer square root and the held distance.
// ----------------------------------------------------------------------------
module rtfp_datapath
    import rtfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_slots            i_slots,
    input  t_dp_cmd           i_cmd,
    output logic [1:0]        o_count,
    output logic              o_present,
    output logic [15:0]       o_distance,
    output logic signed [15:0] o_speed
);

    t_slots                  r_slots;
    logic [15:0]             r_ay;
    logic signed [15:0]      r_v;
    logic                    r_empty;
    logic [31:0]             r_sq;
    logic [31:0]             r_sum;
    logic [TCNT_W-1:0]       r_count;
    logic                    r_found;
    logic [31:0]             r_best;
    logic signed [15:0]      r_best_v;
    logic [31:0]             r_rem;
    logic [31:0]             r_res;
    logic [31:0]             r_bit;
    logic [15:0]             r_held;

    t_slot                   w_slot;
    logic signed [15:0]      w_x;
    logic signed [15:0]      w_y;
    logic signed [15:0]      w_v;
    logic [15:0]             w_ax;
    logic [15:0]             w_ay;
    logic [31:0]             w_trial;

    // Decode the selected slot: flipping bit 15 turns the offset-binary
    // word into two's complement.
    assign w_slot = r_slots[i_cmd.slot];
    assign w_x    = {w_slot[1], w_slot[0]} ^ SIGN_FLIP;
    assign w_y    = {w_slot[3], w_slot[2]} ^ SIGN_FLIP;
    assign w_v    = {w_slot[5], w_slot[4]} ^ SIGN_FLIP;
    // Negating -32768 gives 0x8000, which is right as an unsigned magnitude.
    assign w_ax   = w_x[15] ? 16'(-w_x) : 16'(w_x);
    assign w_ay   = w_y[15] ? 16'(-w_y) : 16'(w_y);

    assign w_trial = r_res + r_bit;

    // Slot capture, decode and squared range, one multiplication per cycle.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slots <= i_slots;
        end
        if (i_cmd.dec) begin
            r_ay    <= w_ay;
            r_v     <= w_v;
            r_empty <= ({w_slot[1], w_slot[0]} == EMPTY_WORD) &&
                       ({w_slot[3], w_slot[2]} == EMPTY_WORD) &&
                       ({w_slot[5], w_slot[4]} == EMPTY_WORD);
            r_sq    <= 32'(w_ax) * 32'(w_ax);
        end
        if (i_cmd.add) begin
            r_sum <= r_sq + 32'(r_ay) * 32'(r_ay);
        end
    end

    // Count and nearest search; the first slot wins on equal sums.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_found <= 1'b0;
        end else if (i_load) begin
            r_count <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.cmp && !r_empty) begin
            r_count <= r_count + TCNT_W'(1);
            if (!r_found || (r_sum < r_best)) begin
                r_found  <= 1'b1;
                r_best   <= r_sum;
                r_best_v <= r_v;
            end
        end
    end

    // Integer square root, one result bit per step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_init) begin
            r_rem <= r_best;
            r_res <= '0;
            r_bit <= 32'h4000_0000;
        end else if (i_cmd.sqrt_step) begin
            if (r_rem >= w_trial) begin
                r_rem <= r_rem - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // Held distance follows the last frame that had a target.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_cmd.finish && r_found) begin
            r_held <= r_res[15:0];
        end
    end

    assign o_count    = (r_count > TCNT_W'(3)) ? 2'd3 : 2'(r_count);
    assign o_present  = r_found;
    assign o_distance = r_found ? r_res[15:0] : r_held;
    assign o_speed    = r_found ? r_best_v : 16'sd0;

endmodule

### rtl/rtfp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame controller
// Sequences the slot decode, the nearest search and the square root for
// one accepted frame, then hands the result to the output register.
// ----------------------------------------------------------------------------
module rtfp_ctrl
    import rtfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctrl_stat i_stat,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_SQI  = 3'd4;
    localparam logic [2:0] S_SQS  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [SLOT_IDX_W-1:0] r_slot;
    logic [SLOT_IDX_W-1:0] n_slot;
    logic [STEP_W-1:0]     r_step;
    logic [STEP_W-1:0]     n_step;

    // Next state and commands.
    always_comb begin
        n_state         = r_state;
        n_slot          = r_slot;
        n_step          = r_step;
        o_cmd           = '0;
        o_cmd.slot      = r_slot;
        unique case (r_state)
            S_IDLE: begin
                if (i_stat.start) begin
                    n_state = S_DEC;
                    n_slot  = '0;
                end
            end
            S_DEC: begin
                o_cmd.dec = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                if (r_slot == SLOT_IDX_W'(TARGET_SLOTS - 1)) begin
                    n_state = S_SQI;
                end else begin
                    n_slot  = r_slot + SLOT_IDX_W'(1);
                    n_state = S_DEC;
                end
            end
            S_SQI: begin
                o_cmd.sqrt_init = 1'b1;
                n_step          = '0;
                n_state         = S_SQS;
            end
            S_SQS: begin
                o_cmd.sqrt_step = 1'b1;
                n_step          = r_step + STEP_W'(1);
                if (r_step == STEP_W'(SQRT_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_step  <= n_step;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
